FILE: sv/cone_isolation_accumulator_defines.svh
// Assertion macros shared by the cone isolation accumulator RTL.
`ifndef CONE_ISOLATION_ACCUMULATOR_DEFINES_SVH
`define CONE_ISOLATION_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CIA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cone isolation accumulator: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cone isolation accumulator: check failed");

`endif

FILE: sv/cia_pkg.sv
// Types, constants and classification function for the cone isolation accumulator.
package cia_pkg;

    localparam int NUM_SUMS      = 14;
    localparam int SUM_WIDTH_DEF = 32;
    localparam int ISO_W         = 32;
    localparam int CAT_W         = 4;
    localparam int PT_W          = 16;
    localparam int ETA_W         = 16;
    localparam int PHI_W         = 15;
    localparam int DZ_W          = 16;
    localparam int PID_W         = 10;
    localparam int VCODE_W       = 2;
    localparam int CONE_W        = 26;
    localparam int CFG_DATA_W    = 26;
    localparam int CFG_IDX_W     = 3;
    localparam int S_DATA_W      = 80;

    // Difference widths and squares
    localparam int DETA_W   = ETA_W + 1;
    localparam int DPHI_W   = PHI_W + 2;
    localparam int ETA_SQ_W = 32;
    localparam int PHI_SQ_W = 28;
    localparam int DR2_W    = 33;

    localparam logic signed [DPHI_W-1:0] PHI_PI     = 17'sd12868;
    localparam logic signed [DPHI_W-1:0] PHI_TWO_PI = 17'sd25736;

    localparam logic [CONE_W-1:0] CONE_OUTER_RST = 26'd1509949;
    localparam logic [CONE_W-1:0] CONE_INNER_RST = 26'd1;
    localparam logic [DZ_W-1:0]   DZ_LIMIT_RST   = 16'd410;

    localparam logic [PID_W-1:0] PID_CHARGED  = 10'd211;
    localparam logic [PID_W-1:0] PID_NEUTRAL  = 10'd130;
    localparam logic [PID_W-1:0] PID_PHOTON   = 10'd22;
    localparam logic [PID_W-1:0] PID_ELECTRON = 10'd11;
    localparam logic [PID_W-1:0] PID_MUON     = 10'd13;
    localparam logic [PID_W-1:0] PID_FWD_HAD  = 10'd1;
    localparam logic [PID_W-1:0] PID_FWD_EM   = 10'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK_ETA  = 3'd0,
        REG_TRACK_PHI  = 3'd1,
        REG_CONE_OUTER = 3'd2,
        REG_CONE_INNER = 3'd3,
        REG_DZ_LIMIT   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        PAIR_CHARGED  = 3'd0,
        PAIR_NEUTRAL  = 3'd1,
        PAIR_PHOTON   = 3'd2,
        PAIR_ELECTRON = 3'd3,
        PAIR_MUON     = 3'd4,
        PAIR_FORWARD  = 3'd5,
        PAIR_LOST     = 3'd6
    } pair_t;

    typedef struct packed {
        logic  hit;
        pair_t pair;
    } cls_t;

    function automatic cls_t classify(input logic lost, input logic [PID_W-1:0] pid);
        cls_t c;
        c.hit  = 1'b1;
        c.pair = PAIR_LOST;
        if (!lost)
        begin
            case (pid) inside
                PID_CHARGED:              c.pair = PAIR_CHARGED;
                PID_NEUTRAL:              c.pair = PAIR_NEUTRAL;
                PID_PHOTON:               c.pair = PAIR_PHOTON;
                PID_ELECTRON:             c.pair = PAIR_ELECTRON;
                PID_MUON:                 c.pair = PAIR_MUON;
                PID_FWD_HAD, PID_FWD_EM:  c.pair = PAIR_FORWARD;
                default:                  c.hit  = 1'b0;
            endcase
        end
        return c;
    endfunction

endpackage

FILE: sv/cone_isolation_accumulator.sv
// Cone isolation accumulator: annulus selection and 14 saturating pt sums per track.
//
// Input stream (s_*): one candidate word per handshake. s_tuser is the lost-track flag,
// s_tlast marks the last candidate of the reference track's set. Words are taken one per
// cycle; a set's sums are snapshot into an output bank when its last word leaves the
// accumulate stage, and the next set starts accumulating from zero in the same cycle.
// Output stream (m_*): 14 words per set, category in m_tuser (0..13), saturated sum in
// m_tdata, m_tlast on the fourteenth. The first word is valid after the last input word
// passes stages 1 and 2 into the bank; then one word per cycle while m_tready is high.
// Throughput: one input word per cycle. The only input stall comes from the single output
// bank: a last word that reaches the accumulate stage while the previous set's 14 words
// are not yet all taken holds the pipeline (s_tready low) until the bank drains.
// A stalled receiver therefore holds the bank, and through it, at most one set boundary.
// Configuration (wr_en, wr_index, wr_data) writes take effect at once and are meant to be
// done only while the block is idle.
// Reset (rst_n, async, low) empties the pipeline and bank, clears all sums and loads the
// register defaults.
module cone_isolation_accumulator
    import cia_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // abs_particle_id[9:0], cand_eta[25:10], cand_phi[40:26], vertex_code[42:41],
    // dz_value[58:43], cand_pt[74:59], zero fill [79:75]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // from_lost_list[0]
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // iso_sum[31:0]
    output logic [ISO_W-1:0]      m_tdata,
    // category[3:0]
    output logic [CAT_W-1:0]      m_tuser,
    output logic                  m_tlast,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

`include "cone_isolation_accumulator_defines.svh"

    localparam int EXT_W = (SUM_WIDTH > ISO_W) ? SUM_WIDTH : ISO_W;
    localparam logic [CAT_W-1:0] LAST_CAT = CAT_W'(NUM_SUMS - 1);

    // configuration
    logic signed [ETA_W-1:0] track_eta_reg;
    logic signed [PHI_W-1:0] track_phi_reg;
    logic [CONE_W-1:0]       cone_outer_reg;
    logic [CONE_W-1:0]       cone_inner_reg;
    logic [DZ_W-1:0]         dz_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_eta_reg  <= '0;
            track_phi_reg  <= '0;
            cone_outer_reg <= CONE_OUTER_RST;
            cone_inner_reg <= CONE_INNER_RST;
            dz_limit_reg   <= DZ_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_TRACK_ETA:  track_eta_reg  <= wr_data[ETA_W-1:0];
                REG_TRACK_PHI:  track_phi_reg  <= wr_data[PHI_W-1:0];
                REG_CONE_OUTER: cone_outer_reg <= wr_data[CONE_W-1:0];
                REG_CONE_INNER: cone_inner_reg <= wr_data[CONE_W-1:0];
                REG_DZ_LIMIT:   dz_limit_reg   <= wr_data[DZ_W-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg;
    logic v2_reg;
    logic last2_reg;
    logic bank_valid_reg;
    logic [CAT_W-1:0] out_idx_reg;
    logic m_fire;
    logic bank_free;
    logic advance;
    logic s_fire;
    logic fire3;

    assign m_fire    = bank_valid_reg && m_tready;
    assign bank_free = !bank_valid_reg || (m_fire && (out_idx_reg == LAST_CAT));
    assign advance   = !(v2_reg && last2_reg) || bank_free;
    assign s_tready  = advance;
    assign s_fire    = s_tvalid && advance;
    assign fire3     = v2_reg && advance;

    // stage 1: input register
    logic                    lost1_reg;
    logic [PID_W-1:0]        pid1_reg;
    logic signed [ETA_W-1:0] eta1_reg;
    logic signed [PHI_W-1:0] phi1_reg;
    logic [VCODE_W-1:0]      vcode1_reg;
    logic signed [DZ_W-1:0]  dz1_reg;
    logic [PT_W-1:0]         pt1_reg;
    logic                    last1_reg;

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            pid1_reg   <= s_tdata[9:0];
            eta1_reg   <= s_tdata[25:10];
            phi1_reg   <= s_tdata[40:26];
            vcode1_reg <= s_tdata[42:41];
            dz1_reg    <= s_tdata[58:43];
            pt1_reg    <= s_tdata[74:59];
            lost1_reg  <= s_tuser;
            last1_reg  <= s_tlast;
        end
    end

    // stage 1 logic: distances, squares, class
    logic signed [DETA_W-1:0]   deta;
    logic signed [DPHI_W-1:0]   dphi_raw;
    logic signed [DPHI_W-1:0]   dphi;
    logic signed [2*DETA_W-1:0] eta_prod;
    logic signed [2*DPHI_W-1:0] phi_prod;
    logic signed [DZ_W:0]       dz_ext;
    logic [DZ_W:0]              abs_dz;
    logic                       pv;
    cls_t                       cls1;

    always_comb
    begin
        deta     = DETA_W'(eta1_reg) - DETA_W'(track_eta_reg);
        dphi_raw = DPHI_W'(phi1_reg) - DPHI_W'(track_phi_reg);
        if (dphi_raw > PHI_PI)
            dphi = dphi_raw - PHI_TWO_PI;
        else if (dphi_raw < -PHI_PI)
            dphi = dphi_raw + PHI_TWO_PI;
        else
            dphi = dphi_raw;
        eta_prod = deta * deta;
        phi_prod = dphi * dphi;
        dz_ext   = (DZ_W+1)'(dz1_reg);
        abs_dz   = dz_ext[DZ_W] ? (DZ_W+1)'(-dz_ext) : dz_ext;
        pv       = (vcode1_reg > 2'd1) || (abs_dz < {1'b0, dz_limit_reg});
        cls1     = classify(lost1_reg, pid1_reg);
    end

    // stage 2 register
    logic [ETA_SQ_W-1:0] eta_sq2_reg;
    logic [PHI_SQ_W-1:0] phi_sq2_reg;
    logic                hit2_reg;
    logic [CAT_W-1:0]    cat2_reg;
    logic [PT_W-1:0]     pt2_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            eta_sq2_reg <= eta_prod[ETA_SQ_W-1:0];
            phi_sq2_reg <= phi_prod[PHI_SQ_W-1:0];
            hit2_reg    <= cls1.hit;
            cat2_reg    <= {cls1.pair, !pv};
            pt2_reg     <= pt1_reg;
            last2_reg   <= last1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_fire;
            v2_reg <= v1_reg;
        end
    end

    // stage 3: annulus test and accumulate
    logic [SUM_WIDTH-1:0] sums_reg [NUM_SUMS];
    logic [SUM_WIDTH-1:0] sums_next [NUM_SUMS];
    logic [ISO_W-1:0]     bank_reg [NUM_SUMS];
    logic [ISO_W-1:0]     snap [NUM_SUMS];
    logic [DR2_W-1:0]     dr2;
    logic                 in_cone;
    logic                 add_en;
    logic [SUM_WIDTH:0]   acc_wide;
    logic [SUM_WIDTH-1:0] acc_val;
    logic [EXT_W-1:0]     sum_ext;
    logic                 set_done;

    always_comb
    begin
        dr2      = DR2_W'(eta_sq2_reg) + DR2_W'(phi_sq2_reg);
        in_cone  = (dr2 < DR2_W'(cone_outer_reg)) && (dr2 >= DR2_W'(cone_inner_reg));
        add_en   = fire3 && hit2_reg && in_cone;
        set_done = fire3 && last2_reg;
        acc_wide = {1'b0, sums_reg[cat2_reg]} + (SUM_WIDTH+1)'(pt2_reg);
        acc_val  = acc_wide[SUM_WIDTH] ? '1 : acc_wide[SUM_WIDTH-1:0];
        for (int k = 0; k < NUM_SUMS; k++)
        begin
            sums_next[k] = (add_en && (cat2_reg == CAT_W'(k))) ? acc_val : sums_reg[k];
            sum_ext      = EXT_W'(sums_next[k]);
            snap[k]      = (sum_ext > EXT_W'({ISO_W{1'b1}})) ? '1 : sum_ext[ISO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SUMS; k++)
                sums_reg[k] <= '0;
        end
        else if (fire3)
        begin
            for (int k = 0; k < NUM_SUMS; k++)
                sums_reg[k] <= last2_reg ? '0 : sums_next[k];
        end
    end

    // output bank: shifts toward entry 0 on each taken word
    always_ff @(posedge clk)
    begin
        if (set_done)
        begin
            for (int k = 0; k < NUM_SUMS; k++)
                bank_reg[k] <= snap[k];
        end
        else if (m_fire)
        begin
            for (int k = 0; k < NUM_SUMS - 1; k++)
                bank_reg[k] <= bank_reg[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_valid_reg <= 1'b0;
            out_idx_reg    <= '0;
        end
        else if (set_done)
        begin
            bank_valid_reg <= 1'b1;
            out_idx_reg    <= '0;
        end
        else if (m_fire)
        begin
            if (out_idx_reg == LAST_CAT)
            begin
                bank_valid_reg <= 1'b0;
                out_idx_reg    <= '0;
            end
            else
                out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    assign m_tvalid = bank_valid_reg;
    assign m_tdata  = bank_reg[0];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = out_idx_reg == LAST_CAT;

    `CIA_ASSERT_IMPL(a_stall_blocks_input, v2_reg && last2_reg && !bank_free, !s_tready)
    `CIA_ASSERT_NEXT(a_set_done_loads_bank, set_done, m_tvalid && (m_tuser == '0))
    `CIA_ASSERT_NEXT(a_burst_continues, m_fire && !m_tlast && !set_done,
                     m_tvalid && (out_idx_reg == $past(out_idx_reg) + 1'b1))
    `CIA_ASSERT_IMPL(a_idx_in_range, m_tvalid, out_idx_reg <= LAST_CAT)

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the cone isolation accumulator: directed and random candidate sets.
module testbench;
    import cia_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic                     lost;
        logic [PID_W-1:0]         pid;
        logic signed [ETA_W-1:0]  eta;
        logic signed [PHI_W-1:0]  phi;
        logic [VCODE_W-1:0]       vcode;
        logic signed [DZ_W-1:0]   dz;
        logic [PT_W-1:0]          pt;
        logic                     last;
    } cand_t;

    typedef struct {
        logic [CAT_W-1:0] cat;
        logic [ISO_W-1:0] total;
        logic             is_last;
    } sum_word_t;

    // Predicts the 14 category sums per track and checks the emitted words.
    class iso_scoreboard;
        logic signed [ETA_W-1:0] trk_eta;
        logic signed [PHI_W-1:0] trk_phi;
        logic [CONE_W-1:0]       outer_sq;
        logic [CONE_W-1:0]       inner_sq;
        logic [DZ_W-1:0]         dz_cut;
        logic [ISO_W-1:0]        pt_sums [NUM_SUMS];
        sum_word_t               sums_due [$];
        int                      errors;

        function new();
            trk_eta  = '0;
            trk_phi  = '0;
            outer_sq = CONE_OUTER_RST;
            inner_sq = CONE_INNER_RST;
            dz_cut   = DZ_LIMIT_RST;
            foreach (pt_sums[k]) pt_sums[k] = '0;
            errors   = 0;
        endfunction

        function void write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TRACK_ETA:  trk_eta  = val[ETA_W-1:0];
                REG_TRACK_PHI:  trk_phi  = val[PHI_W-1:0];
                REG_CONE_OUTER: outer_sq = val[CONE_W-1:0];
                REG_CONE_INNER: inner_sq = val[CONE_W-1:0];
                REG_DZ_LIMIT:   dz_cut   = val[DZ_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_candidate(input cand_t c);
            logic signed [ETA_W:0]  deta;
            logic signed [PHI_W+1:0] dphi;
            longint                 de, dp, dr2, adz;
            logic [ISO_W:0]         acc;
            pair_t                  pr;
            bit                     listed;
            bit                     pv;
            int                     slot;
            sum_word_t              w;
            listed = 1'b1;
            pr     = PAIR_LOST;
            if (!c.lost)
            begin
                if (c.pid == PID_CHARGED)                            pr = PAIR_CHARGED;
                else if (c.pid == PID_NEUTRAL)                       pr = PAIR_NEUTRAL;
                else if (c.pid == PID_PHOTON)                        pr = PAIR_PHOTON;
                else if (c.pid == PID_ELECTRON)                      pr = PAIR_ELECTRON;
                else if (c.pid == PID_MUON)                          pr = PAIR_MUON;
                else if (c.pid == PID_FWD_HAD || c.pid == PID_FWD_EM) pr = PAIR_FORWARD;
                else                                                 listed = 1'b0;
            end
            if (listed)
            begin
                deta = c.eta - trk_eta;
                dphi = c.phi - trk_phi;
                // fold azimuth difference into [-pi, pi]
                if (dphi > PHI_PI)
                    dphi = dphi - PHI_TWO_PI;
                else if (dphi < -PHI_PI)
                    dphi = dphi + PHI_TWO_PI;
                de  = deta;
                dp  = dphi;
                dr2 = de * de + dp * dp;
                if (dr2 < longint'(outer_sq) && dr2 >= longint'(inner_sq))
                begin
                    adz  = c.dz;
                    if (adz < 0)
                        adz = -adz;
                    pv   = (c.vcode > 2'd1) || (adz < longint'(dz_cut));
                    slot = int'(pr) * 2 + (pv ? 0 : 1);
                    acc  = {1'b0, pt_sums[slot]} + c.pt;
                    pt_sums[slot] = acc[ISO_W] ? '1 : acc[ISO_W-1:0];
                end
            end
            if (c.last)
            begin
                for (int k = 0; k < NUM_SUMS; k++)
                begin
                    w.cat     = CAT_W'(k);
                    w.total   = pt_sums[k];
                    w.is_last = (k == NUM_SUMS - 1);
                    sums_due.push_back(w);
                    pt_sums[k] = '0;
                end
            end
        endfunction

        function void check_sum_word(input logic [CAT_W-1:0] cat, input logic [ISO_W-1:0] total,
                                     input logic is_last);
            sum_word_t w;
            if (sums_due.size() == 0)
            begin
                $display("%0t: unexpected sum word: category %0d sum %0d last %0b",
                         $time, cat, total, is_last);
                errors++;
                return;
            end
            w = sums_due.pop_front();
            if (cat !== w.cat)
            begin
                $display("%0t: category mismatch: expected %0d, got %0d", $time, w.cat, cat);
                errors++;
            end
            if (total !== w.total)
            begin
                $display("%0t: sum mismatch (category %0d): expected %0d, got %0d",
                         $time, w.cat, w.total, total);
                errors++;
            end
            if (is_last !== w.is_last)
            begin
                $display("%0t: last flag mismatch (category %0d): expected %0b, got %0b",
                         $time, w.cat, w.is_last, is_last);
                errors++;
            end
        endfunction

        function int words_due();
            return sums_due.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [ISO_W-1:0]      m_tdata;
    logic [CAT_W-1:0]      m_tuser;
    logic                  m_tlast;
    logic                  wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data  = '0;

    iso_scoreboard sb = new();

    int src_idle   = 0;
    int sink_stall = 0;
    logic hold_go  = 1'b0;
    bit hold_used  = 1'b0;
    int hold_left  = 0;
    int cycles     = 0;

    cone_isolation_accumulator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sum_word(m_tuser, m_tdata, m_tlast);
    end

    task automatic send_word(input cand_t c);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, c.pt, c.dz, c.vcode, c.phi, c.eta, c.pid};
        s_tuser  <= c.lost;
        s_tlast  <= c.last;
        do @(posedge clk); while (!s_tready);
        sb.note_candidate(c);
        if ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
        end
    endtask

    // wait for every due sum word, then let the pipeline settle
    task automatic quiesce();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (sb.words_due() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_config(input logic signed [ETA_W-1:0] eta,
                                input logic signed [PHI_W-1:0] phi,
                                input logic [CONE_W-1:0] outer,
                                input logic [CONE_W-1:0] inner,
                                input logic [DZ_W-1:0] dzl);
        reg_idx_t              idx  [5];
        logic [CFG_DATA_W-1:0] vals [5];
        idx  = '{REG_TRACK_ETA, REG_TRACK_PHI, REG_CONE_OUTER, REG_CONE_INNER, REG_DZ_LIMIT};
        vals = '{CFG_DATA_W'(unsigned'(eta)), CFG_DATA_W'(unsigned'(phi)), outer, inner,
                 CFG_DATA_W'(dzl)};
        for (int i = 0; i < 5; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= idx[i];
            wr_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        wr_en <= 1'b0;
    endtask

    function automatic cand_t mk(input logic lost, input logic [PID_W-1:0] pid,
                                 input int eta, input int phi, input int vcode,
                                 input int dz, input int pt, input logic last);
        cand_t c;
        c.lost  = lost;
        c.pid   = pid;
        c.eta   = ETA_W'(eta);
        c.phi   = PHI_W'(phi);
        c.vcode = VCODE_W'(vcode);
        c.dz    = DZ_W'(dz);
        c.pt    = PT_W'(pt);
        c.last  = last;
        return c;
    endfunction

    // mostly candidates near the track axis, some scattered anywhere
    function automatic cand_t make_cand();
        cand_t            c;
        int               p;
        int               lim;
        logic [PID_W-1:0] ids [7];
        ids     = '{PID_CHARGED, PID_NEUTRAL, PID_PHOTON, PID_ELECTRON, PID_MUON,
                    PID_FWD_HAD, PID_FWD_EM};
        c.lost  = ($urandom_range(0, 4) == 0);
        c.pid   = ($urandom_range(0, 9) < 8) ? ids[$urandom_range(0, 6)]
                                             : PID_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 8)
        begin
            c.eta = sb.trk_eta + ETA_W'($urandom_range(0, 2800)) - ETA_W'(1400);
            p = int'(sb.trk_phi) + int'($urandom_range(0, 2800)) - 1400;
            if (p > 12868)
                p -= 25736;
            else if (p < -12868)
                p += 25736;
        end
        else
        begin
            c.eta = ETA_W'($urandom);
            p = int'($urandom_range(0, 25736)) - 12868;
        end
        c.phi   = PHI_W'(p);
        c.vcode = VCODE_W'($urandom_range(0, 3));
        lim     = int'(sb.dz_cut);
        if ($urandom_range(0, 1) == 0)
            c.dz = DZ_W'(int'($urandom_range(0, 2 * lim + 2)) - lim - 1);
        else
            c.dz = DZ_W'($urandom);
        c.pt    = ($urandom_range(0, 15) == 0) ? '1 : PT_W'($urandom);
        c.last  = 1'b0;
        return c;
    endfunction

    task automatic run_sets(input int n_items, input int max_set);
        int    left;
        cand_t c;
        left = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (left == 0)
                left = $urandom_range(1, max_set);
            c = make_cand();
            left--;
            c.last = (left == 0) || (i == n_items - 1);
            send_word(c);
        end
    endtask

    initial
    begin
        int idle_src  [4];
        int idle_sink [4];
        idle_src  = '{0, 69, 0, 11};
        idle_sink = '{0, 0, 69, 11};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: veto edge, outer edge, vertex class, id list
        send_word(mk(0, PID_CHARGED, 0, 0, 2, 0, 100, 0));
        send_word(mk(0, PID_CHARGED, 1, 0, 2, 0, 7, 0));
        send_word(mk(0, PID_NEUTRAL, 1228, 0, 2, 0, 300, 0));
        send_word(mk(0, PID_PHOTON, 0, 1229, 3, 0, 500, 0));
        send_word(mk(0, PID_ELECTRON, -5, 3, 0, 410, 1000, 0));
        send_word(mk(0, PID_MUON, 20, -20, 1, -409, 65535, 0));
        send_word(mk(0, PID_FWD_HAD, -100, 100, 1, -32768, 0, 0));
        send_word(mk(0, PID_FWD_EM, 100, -100, 3, 32767, 42, 0));
        send_word(mk(1, 10'd0, 10, 10, 0, 1000, 77, 0));
        send_word(mk(1, 10'd1023, -10, -10, 2, 0, 88, 0));
        send_word(mk(0, 10'd1023, 0, 5, 2, 0, 999, 0));
        send_word(mk(0, 10'd0, 5, 0, 2, 0, 999, 0));
        send_word(mk(0, PID_CHARGED, 32767, 12868, 0, 0, 1, 1));
        send_word(mk(0, 10'd1023, -32768, -12868, 0, 0, 65535, 1));
        quiesce();

        // widest annulus, phi wrap at both ends
        apply_config(-16'sd32768, 15'sd12868, '1, '0, 16'hFFFF);
        send_word(mk(0, PID_CHARGED, -32768, -12868, 0, -32768, 65535, 0));
        send_word(mk(0, PID_NEUTRAL, 32767, 0, 0, 0, 5, 0));
        send_word(mk(0, PID_PHOTON, -32000, -12000, 0, 100, 6, 0));
        send_word(mk(1, PID_MUON, -32768, 12868, 1, 0, 65535, 1));
        quiesce();

        // empty annulus
        apply_config(16'sd32767, -15'sd12868, 26'd1000, 26'd1000, 16'd0);
        send_word(mk(0, PID_CHARGED, 32767, -12868, 3, 0, 10, 0));
        send_word(mk(0, PID_ELECTRON, 32757, -12868, 0, 0, 20, 0));
        send_word(mk(1, 10'd5, 32767, 12868, 0, 0, 9, 1));
        quiesce();

        // zero dz cut: only the vertex code makes a primary-vertex candidate
        apply_config(16'sd32767, -15'sd12868, 26'd1000, 26'd0, 16'd0);
        send_word(mk(0, PID_ELECTRON, 32767, 12860, 1, 0, 3, 0));
        send_word(mk(0, PID_MUON, 32760, -12860, 2, 0, 4, 1));
        quiesce();

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 0)
                apply_config(ETA_W'($urandom), PHI_W'(int'($urandom_range(0, 25736)) - 12868),
                             CONE_OUTER_RST, CONE_INNER_RST, DZ_LIMIT_RST);
            else
                apply_config(ETA_W'($urandom), PHI_W'(int'($urandom_range(0, 25736)) - 12868),
                             CONE_W'($urandom_range(20000, 3000000)),
                             CONE_W'($urandom_range(0, 30000)),
                             DZ_W'($urandom_range(0, 3000)));
            src_idle    = idle_src[ph];
            sink_stall <= idle_sink[ph];
            run_sets(110, 8);
            quiesce();
        end

        // long receiver hold-off with short sets: the output bank fills and input stalls
        src_idle    = 0;
        sink_stall <= 0;
        hold_go    <= 1'b1;
        run_sets(40, 3);
        quiesce();

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
